@@ rtl/core/simmem_pkg.sv @@
// ----------------------------------------------------------------------------
// simmem_pkg
// Access codes, size codes and status codes shared by the simulation memory
// and its port checker.
// ----------------------------------------------------------------------------
package simmem_pkg;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_FETCH     = 2'd2,
        OP_EXT_WRITE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SZ_BYTE  = 2'd0,
        SZ_HALF  = 2'd1,
        SZ_WORD  = 2'd2,
        SZ_DWORD = 2'd3
    } t_size;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_MISALIGN = 2'd2
    } t_status;

    localparam logic [1:0] FETCH_FULL_MARK = 2'b11;

    function automatic logic [63:0] size_mask(input logic [1:0] size);
        logic [63:0] m;
        unique case (t_size'(size))
            SZ_BYTE:  m = 64'h0000_0000_0000_00FF;
            SZ_HALF:  m = 64'h0000_0000_0000_FFFF;
            SZ_WORD:  m = 64'h0000_0000_FFFF_FFFF;
            SZ_DWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  m = 64'h0;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] size_bytes_en(input logic [1:0] size);
        logic [7:0] m;
        unique case (t_size'(size))
            SZ_BYTE:  m = 8'h01;
            SZ_HALF:  m = 8'h03;
            SZ_WORD:  m = 8'h0F;
            SZ_DWORD: m = 8'hFF;
            default:  m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/sim_memory_with_tohost_port.sv @@
// ----------------------------------------------------------------------------
// sim_memory_with_tohost_port
// Byte-addressed little-endian simulation memory with a host port. Rows of
// eight bytes are split over an even and an odd bank so that any access of
// up to eight bytes reads or writes one row of each bank.
// ----------------------------------------------------------------------------
//   channel   valid        stall         payload
//   in        i_in_valid   o_in_stall    i_operation i_size_code i_address
//                                        i_write_data
//   out       o_out_valid  i_out_stall   o_read_data o_status o_is_compressed
//                                        o_exit_requested o_exit_value
//                                        o_syscall_request o_syscall_pointer
//                                        o_external_notice o_notice_size
//   cfg       i_cfg_we     -             i_cfg_wdata (tohost address)
//
// one word at a time: the bank read (or byte-enable write) happens at accept,
// the result is built from the registered bank data, and only then is the next
// word taken. after reset a clearing pass zeroes both banks with o_in_stall
// high; configuration writes are taken during the pass.
// a word waiting in the output register holds off the next input word only
// while i_out_stall is high.
// ----------------------------------------------------------------------------
module sim_memory_with_tohost_port #(
    parameter int MEM_BYTES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [1:0]         i_size_code,
    input  logic [31:0]        i_address,
    input  logic [63:0]        i_write_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [63:0]        o_read_data,
    output logic [1:0]         o_status,
    output logic               o_is_compressed,
    output logic               o_exit_requested,
    output logic signed [31:0] o_exit_value,
    output logic               o_syscall_request,
    output logic [63:0]        o_syscall_pointer,
    output logic               o_external_notice,
    output logic [3:0]         o_notice_size
);

    localparam int ROWS       = (MEM_BYTES + 7) / 8;
    localparam int BANK_DEPTH = ROWS / 2 + 1;
    localparam int BW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
    localparam logic [BW-1:0] CLR_LAST = BW'(BANK_DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state      r_state, n_state;
    logic [BW-1:0] r_clr_idx;
    logic [31:0] r_tohost;

    logic [1:0]  r_op;
    logic [1:0]  r_size;
    logic [31:0] r_addr;
    logic [63:0] r_wdata;

    logic        r_exit_flag;
    logic [31:0] r_exit_code;

    logic        r_out_valid;
    logic [63:0] r_out_rdata;
    logic [1:0]  r_out_status;
    logic        r_out_compressed;
    logic        r_out_exit_flag;
    logic [31:0] r_out_exit_code;
    logic        r_out_sys_req;
    logic [63:0] r_out_sys_ptr;
    logic        r_out_notice;
    logic [3:0]  r_out_nsize;

    logic [63:0] mem_even [BANK_DEPTH];
    logic [63:0] mem_odd  [BANK_DEPTH];
    logic [63:0] r_rd_even;
    logic [63:0] r_rd_odd;

    // accept side
    logic          accept;
    logic [3:0]    in_nbytes;
    logic          in_range_ok;
    logic          in_host;
    logic          in_store;
    logic [63:0]   in_wdata;
    logic [29:0]   in_row_p1;
    logic [BW-1:0] in_even_idx;
    logic [BW-1:0] in_odd_idx;
    logic [127:0]  in_wwin;
    logic [15:0]   in_be;

    logic          wr_even_en, wr_odd_en;
    logic [BW-1:0] wr_even_idx, wr_odd_idx;
    logic [63:0]   wr_even_data, wr_odd_data;
    logic [7:0]    wr_even_be, wr_odd_be;

    // lookup side
    logic [3:0]   lk_nbytes;
    logic         lk_range_n, lk_range2, lk_range4;
    logic         lk_host;
    logic [127:0] lk_window;
    logic [127:0] lk_shifted;
    logic [63:0]  lk_rdata;
    logic [1:0]   lk_status;
    logic         lk_compressed;
    logic         lk_sys_req;
    logic [63:0]  lk_sys_ptr;
    logic         lk_notice;
    logic [3:0]   lk_nsize;
    logic         n_exit_flag;
    logic [31:0]  n_exit_code;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        in_nbytes   = 4'b0001 << i_size_code;
        in_range_ok = ({1'b0, i_address} + {29'b0, in_nbytes}) <= MEM_LIMIT;
        in_host     = (i_operation == simmem_pkg::OP_CPU_WRITE) && i_size_code[1]
                      && (i_address == r_tohost);
        in_store    = ((i_operation == simmem_pkg::OP_CPU_WRITE) && !in_host
                       || (i_operation == simmem_pkg::OP_EXT_WRITE)) && in_range_ok;
        in_wdata    = i_write_data & simmem_pkg::size_mask(i_size_code);
        in_row_p1   = {1'b0, i_address[31:3]} + 30'd1;
        in_even_idx = in_row_p1[BW:1];
        in_odd_idx  = i_address[BW+3:4];
        in_wwin     = {64'b0, in_wdata} << {i_address[2:0], 3'b000};
        in_be       = {8'b0, simmem_pkg::size_bytes_en(i_size_code)} << i_address[2:0];
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_even_en   = 1'b1;
            wr_odd_en    = 1'b1;
            wr_even_idx  = r_clr_idx;
            wr_odd_idx   = r_clr_idx;
            wr_even_data = 64'b0;
            wr_odd_data  = 64'b0;
            wr_even_be   = 8'hFF;
            wr_odd_be    = 8'hFF;
        end else begin
            wr_even_en  = accept && in_store;
            wr_odd_en   = accept && in_store;
            wr_even_idx = in_even_idx;
            wr_odd_idx  = in_odd_idx;
            if (i_address[3]) begin
                wr_even_data = in_wwin[127:64];
                wr_even_be   = in_be[15:8];
                wr_odd_data  = in_wwin[63:0];
                wr_odd_be    = in_be[7:0];
            end else begin
                wr_even_data = in_wwin[63:0];
                wr_even_be   = in_be[7:0];
                wr_odd_data  = in_wwin[127:64];
                wr_odd_be    = in_be[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_even_en) begin
            for (int b = 0; b < 8; b++) begin
                if (wr_even_be[b]) begin
                    mem_even[wr_even_idx][b*8 +: 8] <= wr_even_data[b*8 +: 8];
                end
            end
        end
        if (accept) begin
            r_rd_even <= mem_even[in_even_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_odd_en) begin
            for (int b = 0; b < 8; b++) begin
                if (wr_odd_be[b]) begin
                    mem_odd[wr_odd_idx][b*8 +: 8] <= wr_odd_data[b*8 +: 8];
                end
            end
        end
        if (accept) begin
            r_rd_odd <= mem_odd[in_odd_idx];
        end
    end

    always_comb begin
        lk_nbytes  = 4'b0001 << r_size;
        lk_range_n = ({1'b0, r_addr} + {29'b0, lk_nbytes}) <= MEM_LIMIT;
        lk_range2  = ({1'b0, r_addr} + 33'd2) <= MEM_LIMIT;
        lk_range4  = ({1'b0, r_addr} + 33'd4) <= MEM_LIMIT;
        lk_host    = (r_op == simmem_pkg::OP_CPU_WRITE) && r_size[1] && (r_addr == r_tohost);
        lk_window  = r_addr[3] ? {r_rd_even, r_rd_odd} : {r_rd_odd, r_rd_even};
        lk_shifted = lk_window >> {r_addr[2:0], 3'b000};

        lk_rdata      = 64'b0;
        lk_status     = simmem_pkg::ST_OK;
        lk_compressed = 1'b0;
        lk_sys_req    = 1'b0;
        lk_sys_ptr    = 64'b0;
        lk_notice     = 1'b0;
        lk_nsize      = 4'd0;
        n_exit_flag   = r_exit_flag;
        n_exit_code   = r_exit_code;

        priority if (r_op == simmem_pkg::OP_READ) begin
            if (lk_range_n) begin
                lk_rdata = lk_shifted[63:0] & simmem_pkg::size_mask(r_size);
            end else begin
                lk_status = simmem_pkg::ST_RANGE;
            end
        end else if (lk_host) begin
            if (r_wdata != 64'b0) begin
                if (r_wdata[0]) begin
                    n_exit_flag = 1'b1;
                    n_exit_code = r_wdata[32:1];
                end else begin
                    lk_sys_req = 1'b1;
                    lk_sys_ptr = r_wdata;
                end
            end
        end else if (r_op == simmem_pkg::OP_CPU_WRITE || r_op == simmem_pkg::OP_EXT_WRITE) begin
            if (lk_range_n) begin
                if (r_op == simmem_pkg::OP_EXT_WRITE) begin
                    lk_notice = 1'b1;
                    lk_nsize  = lk_nbytes;
                end
            end else begin
                lk_status = simmem_pkg::ST_RANGE;
            end
        end else begin
            if (r_addr[0]) begin
                lk_status = simmem_pkg::ST_MISALIGN;
            end else if (!lk_range2) begin
                lk_status = simmem_pkg::ST_RANGE;
            end else if (lk_shifted[1:0] == simmem_pkg::FETCH_FULL_MARK) begin
                if (lk_range4) begin
                    lk_rdata = {32'b0, lk_shifted[31:0]};
                end else begin
                    lk_status = simmem_pkg::ST_RANGE;
                end
            end else begin
                lk_rdata      = {48'b0, lk_shifted[15:0]};
                lk_compressed = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_idx == CLR_LAST) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_idx       <= '0;
            r_tohost        <= 32'hFFFF_FFFF;
            r_exit_flag     <= 1'b0;
            r_exit_code     <= 32'b0;
            r_out_valid     <= 1'b0;
            r_out_exit_flag <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg_we) begin
                r_tohost <= i_cfg_wdata;
            end
            if (accept) begin
                r_op    <= i_operation;
                r_size  <= i_size_code;
                r_addr  <= i_address;
                r_wdata <= in_wdata;
            end
            if (r_state == S_LOOKUP) begin
                r_exit_flag      <= n_exit_flag;
                r_exit_code      <= n_exit_code;
                r_out_valid      <= 1'b1;
                r_out_rdata      <= lk_rdata;
                r_out_status     <= lk_status;
                r_out_compressed <= lk_compressed;
                r_out_exit_flag  <= n_exit_flag;
                r_out_exit_code  <= n_exit_code;
                r_out_sys_req    <= lk_sys_req;
                r_out_sys_ptr    <= lk_sys_ptr;
                r_out_notice     <= lk_notice;
                r_out_nsize      <= lk_nsize;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out_rdata;
    assign o_status          = r_out_status;
    assign o_is_compressed   = r_out_compressed;
    assign o_exit_requested  = r_out_exit_flag;
    assign o_exit_value      = r_out_exit_code;
    assign o_syscall_request = r_out_sys_req;
    assign o_syscall_pointer = r_out_sys_ptr;
    assign o_external_notice = r_out_notice;
    assign o_notice_size     = r_out_nsize;

endmodule

@@ rtl/core/simmem_checker.sv @@
// ----------------------------------------------------------------------------
// simmem_port_props
// Port-level checks for the simulation memory, bound to its top level.
// ----------------------------------------------------------------------------
module simmem_port_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [63:0]        o_read_data,
    input logic [1:0]         o_status,
    input logic               o_is_compressed,
    input logic               o_exit_requested,
    input logic signed [31:0] o_exit_value,
    input logic               o_syscall_request,
    input logic [63:0]        o_syscall_pointer,
    input logic               o_external_notice,
    input logic [3:0]         o_notice_size
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_status) && $stable(o_exit_value))
        else $error("output word changed while stalled");

    // exit flag is sticky across words
    a_exit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_exit_requested |=> !o_out_valid || o_exit_requested)
        else $error("exit flag dropped");

    // compressed fetch is a clean 16-bit parcel
    a_compressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_compressed |-> o_status == simmem_pkg::ST_OK
            && o_read_data[63:16] == 48'b0
            && o_read_data[1:0] != simmem_pkg::FETCH_FULL_MARK)
        else $error("bad compressed fetch word");

    // notice comes with a legal size and nothing else
    a_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_external_notice |-> o_status == simmem_pkg::ST_OK
            && !o_syscall_request
            && (o_notice_size == 4'd1 || o_notice_size == 4'd2
                || o_notice_size == 4'd4 || o_notice_size == 4'd8))
        else $error("bad external notice");

    // syscall pointer is even and nonzero
    a_syscall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_syscall_request |-> o_syscall_pointer != 64'b0
            && !o_syscall_pointer[0] && o_status == simmem_pkg::ST_OK)
        else $error("bad syscall pointer");

endmodule

bind sim_memory_with_tohost_port simmem_port_props u_simmem_checker (.*);
